// ===== src/lhbs_pkg.sv =====
package lhbs_pkg;

  // Field and register widths
  localparam int unsigned TpuW        = 21;
  localparam int unsigned NumberW     = 32;
  localparam int unsigned DigitCountW = 4;
  localparam int unsigned PreambleW   = 8;
  localparam int unsigned UnitW       = 4;
  localparam int unsigned CfgIdxW     = 1;

  // Default for the digit limit
  localparam int unsigned MaxDigitsDefault = 8;

  // Segment lengths in blink units
  localparam logic [UnitW-1:0] UnitsShort   = 4'd1;
  localparam logic [UnitW-1:0] UnitsLong    = 4'd4;
  localparam logic [UnitW-1:0] UnitsGap     = 4'd5;
  localparam logic [UnitW-1:0] UnitsEndGap  = 4'd15;

  // Action codes carried by an input word
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } lhbs_action_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOOPING_MODE   = 1'b0,
    CFG_TICKS_PER_UNIT = 1'b1
  } lhbs_cfg_idx_e;

  // Input word as held in the input register
  typedef struct packed {
    logic [1:0]             action;
    logic [NumberW-1:0]     number;
    logic [DigitCountW-1:0] digit_count;
    logic [PreambleW-1:0]   preamble_count;
  } lhbs_item_t;

  // Configuration seen by the sequencer
  typedef struct packed {
    logic            looping_mode;
    logic [TpuW-1:0] ticks_per_unit;
  } lhbs_cfg_t;

endpackage

// ===== src/lhbs_cfg_regs.sv =====
module lhbs_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lhbs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lhbs_pkg::TpuW-1:0]     cfg_data_i,
  output lhbs_pkg::lhbs_cfg_t           cfg_o
);
  import lhbs_pkg::*;

  logic            looping_mode_q;
  logic [TpuW-1:0] tpu_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      looping_mode_q <= 1'b1;
      tpu_q          <= TpuW'(1);
    end else if (cfg_we_i) begin
      unique case (lhbs_cfg_idx_e'(cfg_idx_i))
        CFG_LOOPING_MODE:   looping_mode_q <= cfg_data_i[0];
        CFG_TICKS_PER_UNIT: tpu_q          <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  assign cfg_o.looping_mode   = looping_mode_q;
  assign cfg_o.ticks_per_unit = tpu_q;

endmodule

// ===== src/lhbs_in_stage.sv =====
module lhbs_in_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_vld_i,
  output logic                   in_stall_o,
  input  lhbs_pkg::lhbs_item_t   item_i,
  input  logic                   take_i,
  output logic                   vld_o,
  output lhbs_pkg::lhbs_item_t   item_o
);
  import lhbs_pkg::*;

  logic       vld_q, vld_d;
  lhbs_item_t item_q;
  logic       accept;

  // Stalls the input only while a held word cannot be taken by the sequencer
  assign in_stall_o = vld_q & ~take_i;
  assign accept     = in_vld_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// ===== src/lhbs_seq.sv =====
module lhbs_seq #(
  parameter int unsigned MAX_DIGITS = lhbs_pkg::MaxDigitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  lhbs_pkg::lhbs_item_t item_i,
  input  lhbs_pkg::lhbs_cfg_t  cfg_i,
  output logic                 led_on_o,
  output logic                 busy_res_o
);
  import lhbs_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned KW = (DW > 3) ? DW : 3;

  typedef enum logic [2:0] {
    PH_IDLE, PH_PRE_ON, PH_PRE_OFF, PH_PRE_GAP,
    PH_BIT_ON, PH_BIT_OFF, PH_DIGIT_GAP, PH_END_GAP
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [UnitW-1:0]     ut_q, ut_d;
  logic [TpuW-1:0]      presc_q, presc_d;
  logic [NumberW-1:0]   sv_q, sv_d;
  logic [DW-1:0]        di_q, di_d;
  logic [1:0]           bi_q, bi_d;
  logic [DW-1:0]        dt_q, dt_d;
  logic [PreambleW-1:0] pt_q, pt_d;
  logic [PreambleW-1:0] pl_q, pl_d;
  logic                 led_q, busy_q;

  logic                 do_pass, do_digits, do_bit, do_end;
  logic [TpuW-1:0]      tpu_eff;
  logic [TpuW-1:0]      presc_inc;
  logic [UnitW-1:0]     ut_dec;
  logic [DW-1:0]        di_inc;

  // Bit of the value shown for a digit and bit position, MSB first
  function automatic logic cur_bit(logic [NumberW-1:0] sv, logic [DW-1:0] dt,
                                   logic [DW-1:0] di, logic [1:0] bi);
    logic [DW-1:0] k;
    logic [KW-1:0] k_ext;
    logic [4:0]    pos;
    k     = dt - di - DW'(1);
    k_ext = KW'(k);
    pos   = {k_ext[2:0], 2'b11} - {3'b000, bi};
    if (di >= dt) begin
      return 1'b0;
    end else if (int'(k) > 7) begin
      // digits beyond the 32-bit value read as zero
      return 1'b0;
    end else begin
      return sv[pos];
    end
  endfunction

  assign tpu_eff   = (cfg_i.ticks_per_unit == '0) ? TpuW'(1) : cfg_i.ticks_per_unit;
  assign presc_inc = presc_q + TpuW'(1);
  assign ut_dec    = (ut_q != '0) ? ut_q - UnitW'(1) : ut_q;
  assign di_inc    = di_q + DW'(1);

  // Next state for one word
  always_comb begin
    phase_d   = phase_q;
    ut_d      = ut_q;
    presc_d   = presc_q;
    sv_d      = sv_q;
    di_d      = di_q;
    bi_d      = bi_q;
    dt_d      = dt_q;
    pt_d      = pt_q;
    pl_d      = pl_q;
    do_pass   = 1'b0;
    do_digits = 1'b0;
    do_bit    = 1'b0;
    do_end    = 1'b0;

    priority if (item_i.action == ACT_START) begin
      sv_d    = item_i.number;
      dt_d    = (int'(item_i.digit_count) > int'(MAX_DIGITS)) ? DW'(MAX_DIGITS)
                                                              : DW'(item_i.digit_count);
      pt_d    = item_i.preamble_count;
      pl_d    = item_i.preamble_count;
      di_d    = '0;
      bi_d    = '0;
      presc_d = '0;
      do_pass = 1'b1;
    end else if (item_i.action == ACT_STOP) begin
      phase_d = PH_IDLE;
      ut_d    = '0;
      presc_d = '0;
    end else if (item_i.action == ACT_TICK && phase_q != PH_IDLE) begin
      if (presc_inc >= tpu_eff) begin
        presc_d = '0;
        ut_d    = ut_dec;
        if (ut_dec == '0) begin
          // segment done: move on
          unique case (phase_q)
            PH_PRE_ON: begin
              phase_d = PH_PRE_OFF;
              ut_d    = UnitsShort;
            end
            PH_PRE_OFF: begin
              pl_d = pl_q - PreambleW'(1);
              if (pl_d != '0) begin
                phase_d = PH_PRE_ON;
                ut_d    = UnitsShort;
              end else begin
                phase_d = PH_PRE_GAP;
                ut_d    = UnitsGap;
              end
            end
            PH_PRE_GAP: do_digits = 1'b1;
            PH_BIT_ON: begin
              phase_d = PH_BIT_OFF;
              ut_d    = UnitsShort;
            end
            PH_BIT_OFF: begin
              if (bi_q == 2'd3) begin
                bi_d    = '0;
                phase_d = PH_DIGIT_GAP;
                ut_d    = UnitsGap;
              end else begin
                bi_d   = bi_q + 2'd1;
                do_bit = 1'b1;
              end
            end
            PH_DIGIT_GAP: begin
              di_d = di_inc;
              if (di_inc < dt_q) begin
                do_bit = 1'b1;
              end else begin
                do_end = 1'b1;
              end
            end
            PH_END_GAP: do_pass = 1'b1;
            default: begin
              phase_d = PH_IDLE;
              ut_d    = '0;
            end
          endcase
        end
      end else begin
        presc_d = presc_inc;
      end
    end else begin
      // idle tick or unknown code: nothing changes
    end

    // start of a pass
    if (do_pass) begin
      if (cfg_i.looping_mode) begin
        pl_d = pt_d;
        if (pt_d != '0) begin
          phase_d = PH_PRE_ON;
          ut_d    = UnitsShort;
        end else begin
          phase_d = PH_PRE_GAP;
          ut_d    = UnitsGap;
        end
      end else begin
        do_digits = 1'b1;
      end
    end

    // start of the digit part
    if (do_digits) begin
      di_d = '0;
      bi_d = '0;
      if (dt_d != '0) begin
        do_bit = 1'b1;
      end else begin
        do_end = 1'b1;
      end
    end

    // lit part of one bit
    if (do_bit) begin
      phase_d = PH_BIT_ON;
      ut_d    = cur_bit(sv_d, dt_d, di_d, bi_d) ? UnitsLong : UnitsShort;
    end

    // after the last digit
    if (do_end) begin
      if (cfg_i.looping_mode) begin
        phase_d = PH_END_GAP;
        ut_d    = UnitsEndGap;
      end else begin
        phase_d = PH_IDLE;
        ut_d    = '0;
      end
    end

    if (phase_d == PH_IDLE) begin
      presc_d = '0;
    end
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ut_q    <= '0;
      presc_q <= '0;
      sv_q    <= '0;
      di_q    <= '0;
      bi_q    <= '0;
      dt_q    <= '0;
      pt_q    <= '0;
      pl_q    <= '0;
      led_q   <= 1'b0;
      busy_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      ut_q    <= ut_d;
      presc_q <= presc_d;
      sv_q    <= sv_d;
      di_q    <= di_d;
      bi_q    <= bi_d;
      dt_q    <= dt_d;
      pt_q    <= pt_d;
      pl_q    <= pl_d;
      led_q   <= (phase_d == PH_PRE_ON) || (phase_d == PH_BIT_ON);
      busy_q  <= (phase_d != PH_IDLE);
    end
  end

  assign led_on_o   = led_q;
  assign busy_res_o = busy_q;

  // LED is never lit when no sequence runs
  a_led_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !led_q)
    else $error("LED lit while idle");

  // stop always ends the sequence
  a_stop_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.action == ACT_STOP |=> !busy_q && phase_q == PH_IDLE)
    else $error("stop did not return to idle");

  // looping start with a preamble lights the first blink at once
  a_start_preamble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.action == ACT_START && cfg_i.looping_mode
      && item_i.preamble_count != '0 |=> led_q && phase_q == PH_PRE_ON)
    else $error("preamble blink missing after start");

  // prescaler is cleared whenever the sequencer idles
  a_idle_presc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> presc_q == '0)
    else $error("prescaler running while idle");

endmodule

// ===== src/led_hex_blink_code_sequencer_core.sv =====
// Hex blink-code sequencer for a status LED.
// Input channel (in_vld_i / in_stall_o): one word per tick, start or stop.
//   A start word loads number_i, digit_count_i (saturated to MAX_DIGITS) and
//   preamble_count_i and restarts the display; a stop word ends it at once.
//   Ticks advance the display; ticks_per_unit ticks (0 acts as 1) make one blink unit.
// Output channel (out_vld_o / out_stall_i): one word per input word, giving
//   led_on_o and busy_res_o as they stand after that input word.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 looping_mode, 1 ticks_per_unit); write only while the block is idle.
// Path: an accepted word passes the input register, then the sequencer
//   state and result register.
// Throughput: one word per cycle while out_stall_i is low; the sequencer
//   updates its small counters each time it takes a word.
// A stall on the output holds the result and, once the input register is
//   full, raises in_stall_o in the same cycle; nothing is dropped.
// Reset clears both channels, idles the sequencer and sets looping_mode to 1
//   and ticks_per_unit to 1.
module led_hex_blink_code_sequencer_core #(
  parameter int unsigned MAX_DIGITS = lhbs_pkg::MaxDigitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lhbs_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lhbs_pkg::TpuW-1:0]          cfg_data_i,
  input  logic                               in_vld_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         action_i,
  input  logic [lhbs_pkg::NumberW-1:0]       number_i,
  input  logic [lhbs_pkg::DigitCountW-1:0]   digit_count_i,
  input  logic [lhbs_pkg::PreambleW-1:0]     preamble_count_i,
  output logic                               out_vld_o,
  input  logic                               out_stall_i,
  output logic                               led_on_o,
  output logic                               busy_res_o
);
  import lhbs_pkg::*;

  lhbs_cfg_t  cfg;
  lhbs_item_t in_item, stage_item;
  logic       stage_vld;
  logic       take;
  logic       fire;
  logic       out_vld_q, out_vld_d;

  assign in_item.action         = action_i;
  assign in_item.number         = number_i;
  assign in_item.digit_count    = digit_count_i;
  assign in_item.preamble_count = preamble_count_i;

  lhbs_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  lhbs_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_vld_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (take),
    .vld_o      (stage_vld),
    .item_o     (stage_item)
  );

  // Result register is free when empty or being taken
  assign take = ~out_vld_q | ~out_stall_i;
  assign fire = stage_vld & take;

  lhbs_seq #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .item_i     (stage_item),
    .cfg_i      (cfg),
    .led_on_o   (led_on_o),
    .busy_res_o (busy_res_o)
  );

  // Output valid
  always_comb begin
    out_vld_d = out_vld_q;
    if (fire) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  assign out_vld_o = out_vld_q;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import lhbs_pkg::*;

  localparam int unsigned CycleLimit  = 600_000;
  localparam int unsigned RandWords   = 800;
  localparam int unsigned TailWords   = 120;
  localparam int unsigned SettleDelay = 8;
  localparam int unsigned DigitLimit  = MaxDigitsDefault;
  // Action code with no meaning; the block must ignore it
  localparam logic [1:0] ActNone = 2'd3;
  localparam logic [TpuW-1:0] TpuTop = 21'd1048576;
  localparam logic [TpuW-1:0] TpuAll = '1;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_PRE_ON, SQ_PRE_OFF, SQ_PRE_GAP,
    SQ_BIT_ON, SQ_BIT_OFF, SQ_DIGIT_GAP, SQ_END_GAP
  } blink_phase_e;

  typedef struct packed {
    logic led;
    logic busy;
  } blink_res_t;

  // One row of the directed table: a register write or an input word
  typedef struct packed {
    logic                   is_cfg;
    lhbs_cfg_idx_e          idx;
    logic [TpuW-1:0]        val;
    logic [1:0]             act;
    logic [NumberW-1:0]     num;
    logic [DigitCountW-1:0] dc;
    logic [PreambleW-1:0]   pre;
    logic                   chk;
    blink_res_t             res;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxW-1:0]     cfg_idx_i;
  logic [TpuW-1:0]        cfg_data_i;
  logic                   in_vld_i;
  logic                   in_stall_o;
  logic [1:0]             action_i;
  logic [NumberW-1:0]     number_i;
  logic [DigitCountW-1:0] digit_count_i;
  logic [PreambleW-1:0]   preamble_count_i;
  logic                   out_vld_o;
  logic                   out_stall_i;
  logic                   led_on_o;
  logic                   busy_res_o;

  led_hex_blink_code_sequencer_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .in_vld_i         (in_vld_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .number_i         (number_i),
    .digit_count_i    (digit_count_i),
    .preamble_count_i (preamble_count_i),
    .out_vld_o        (out_vld_o),
    .out_stall_i      (out_stall_i),
    .led_on_o         (led_on_o),
    .busy_res_o       (busy_res_o)
  );

  // Predicted sequencer state and its configuration
  logic            cfg_loop;
  logic [TpuW-1:0] cfg_tpu;
  blink_phase_e    sq_phase;
  int unsigned     sq_units;
  int unsigned     sq_presc;
  int unsigned     sq_digit;
  int unsigned     sq_bit;
  int unsigned     sq_ndig;
  int unsigned     sq_npre;
  int unsigned     sq_preleft;
  logic [31:0]     sq_value;

  blink_res_t  blink_q[$];
  blink_res_t  mon_exp;
  dir_row_t    dir_rows[$];
  logic        gaps_on;
  logic        stall_on;
  int unsigned n_cycles;
  int unsigned n_words;
  int unsigned n_starts;
  int unsigned n_stops;
  int unsigned n_none;
  int unsigned n_cfg;
  int unsigned n_checked;
  int unsigned n_errors;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Run limit
  initial n_cycles = 0;
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d words pending", $time, n_cycles,
               blink_q.size());
      $display("** led_hex_blink_code_sequencer_core: FAILED **");
      $finish;
    end
  end

  // Predictor: load the bit under the digit and bit cursors into BIT_ON
  function automatic void start_bit();
    int unsigned shift;
    logic        one;
    one = 1'b0;
    if (sq_digit < sq_ndig) begin
      shift = 4 * (sq_ndig - 1 - sq_digit);
      if (shift < 32) one = sq_value[shift + 3 - sq_bit];
    end
    sq_phase = SQ_BIT_ON;
    sq_units = one ? UnitsLong : UnitsShort;
  endfunction

  function automatic void end_of_digits();
    if (cfg_loop) begin
      sq_phase = SQ_END_GAP;
      sq_units = UnitsEndGap;
    end else begin
      sq_phase = SQ_IDLE;
      sq_units = 0;
    end
  endfunction

  function automatic void begin_digits();
    sq_digit = 0;
    sq_bit   = 0;
    if (sq_ndig > 0) start_bit();
    else end_of_digits();
  endfunction

  function automatic void begin_pass();
    if (cfg_loop) begin
      sq_preleft = sq_npre;
      sq_phase   = (sq_preleft > 0) ? SQ_PRE_ON : SQ_PRE_GAP;
      sq_units   = (sq_preleft > 0) ? UnitsShort : UnitsGap;
    end else begin
      begin_digits();
    end
  endfunction

  // Predictor: apply one input word, return LED and busy after it
  function automatic blink_res_t blink_step(input logic [1:0] act,
                                            input logic [NumberW-1:0] num,
                                            input logic [DigitCountW-1:0] dc,
                                            input logic [PreambleW-1:0] pre);
    blink_res_t  res;
    int unsigned tpu;
    case (act)
      ACT_START: begin
        sq_value   = num;
        sq_ndig    = (dc > DigitLimit) ? DigitLimit : dc;
        sq_npre    = pre;
        sq_preleft = pre;
        sq_digit   = 0;
        sq_bit     = 0;
        sq_presc   = 0;
        begin_pass();
      end
      ACT_STOP: begin
        sq_phase = SQ_IDLE;
        sq_units = 0;
        sq_presc = 0;
      end
      ACT_TICK: begin
        if (sq_phase != SQ_IDLE) begin
          tpu = (cfg_tpu == 0) ? 1 : cfg_tpu;
          sq_presc++;
          if (sq_presc >= tpu) begin
            sq_presc = 0;
            if (sq_units > 0) sq_units--;
            if (sq_units == 0) begin
              // segment done: move to the next one
              case (sq_phase)
                SQ_PRE_ON: begin
                  sq_phase = SQ_PRE_OFF;
                  sq_units = UnitsShort;
                end
                SQ_PRE_OFF: begin
                  sq_preleft = (sq_preleft - 1) & 8'hFF;
                  sq_phase   = (sq_preleft > 0) ? SQ_PRE_ON : SQ_PRE_GAP;
                  sq_units   = (sq_preleft > 0) ? UnitsShort : UnitsGap;
                end
                SQ_PRE_GAP: begin_digits();
                SQ_BIT_ON: begin
                  sq_phase = SQ_BIT_OFF;
                  sq_units = UnitsShort;
                end
                SQ_BIT_OFF: begin
                  if (sq_bit >= 3) begin
                    sq_bit   = 0;
                    sq_phase = SQ_DIGIT_GAP;
                    sq_units = UnitsGap;
                  end else begin
                    sq_bit++;
                    start_bit();
                  end
                end
                SQ_DIGIT_GAP: begin
                  sq_digit++;
                  if (sq_digit < sq_ndig) start_bit();
                  else end_of_digits();
                end
                SQ_END_GAP: begin_pass();
                default: begin
                  sq_phase = SQ_IDLE;
                  sq_units = 0;
                end
              endcase
            end
          end
        end
      end
      default: ;
    endcase
    if (sq_phase == SQ_IDLE) sq_presc = 0;
    res.led  = (sq_phase == SQ_PRE_ON) || (sq_phase == SQ_BIT_ON);
    res.busy = (sq_phase != SQ_IDLE);
    return res;
  endfunction

  function automatic dir_row_t word_row(input logic [1:0] act, input logic [NumberW-1:0] num,
                                        input logic [DigitCountW-1:0] dc,
                                        input logic [PreambleW-1:0] pre, input logic chk,
                                        input logic led, input logic busy);
    dir_row_t row;
    row          = '0;
    row.act      = act;
    row.num      = num;
    row.dc       = dc;
    row.pre      = pre;
    row.chk      = chk;
    row.res.led  = led;
    row.res.busy = busy;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input lhbs_cfg_idx_e idx, input logic [TpuW-1:0] val);
    dir_row_t row;
    row        = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.val    = val;
    return row;
  endfunction

  // Send one word; valid stays high on return, the caller sends again or lowers it
  task automatic send_word(input logic [1:0] act, input logic [NumberW-1:0] num,
                           input logic [DigitCountW-1:0] dc, input logic [PreambleW-1:0] pre,
                           input logic chk, input blink_res_t typed);
    blink_res_t pred;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_vld_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_vld_i         <= 1'b1;
    action_i         <= act;
    number_i         <= num;
    digit_count_i    <= dc;
    preamble_count_i <= pre;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = blink_step(act, num, dc, pre);
    blink_q.push_back(chk ? typed : pred);
    n_words++;
    if (act == ACT_START) n_starts++;
    if (act == ACT_STOP) n_stops++;
    if (act == ActNone) n_none++;
  endtask

  // Hold off the sender until every expected word has come back
  task automatic drain();
    in_vld_i <= 1'b0;
    while (blink_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input lhbs_cfg_idx_e idx, input logic [TpuW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_LOOPING_MODE) cfg_loop = val[0];
    else cfg_tpu = val;
    n_cfg++;
    @(posedge clk_i);
  endtask

  task automatic send_rand_start();
    logic [DigitCountW-1:0] dc;
    logic [PreambleW-1:0]   pre;
    dc = ($urandom_range(0, 9) == 0) ? DigitCountW'($urandom_range(0, 15))
                                      : DigitCountW'($urandom_range(0, 4));
    case ($urandom_range(0, 9))
      0:       pre = PreambleW'($urandom_range(0, 255));
      1, 2:    pre = PreambleW'($urandom_range(4, 15));
      default: pre = PreambleW'($urandom_range(0, 3));
    endcase
    send_word(ACT_START, $urandom, dc, pre, 1'b0, '0);
  endtask

  // Output stall in random bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checker: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_vld_o && !out_stall_i) begin
      if (blink_q.size() == 0) begin
        $display("%0t: unexpected word led_on=%0b busy_res=%0b", $time, led_on_o, busy_res_o);
        n_errors++;
      end else begin
        mon_exp = blink_q.pop_front();
        n_checked++;
        if (led_on_o !== mon_exp.led) begin
          $display("%0t: led_on expected %0b got %0b", $time, mon_exp.led, led_on_o);
          n_errors++;
        end
        if (busy_res_o !== mon_exp.busy) begin
          $display("%0t: busy_res expected %0b got %0b", $time, mon_exp.busy, busy_res_o);
          n_errors++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    dir_row_t    row;
    int unsigned n_rand;
    int unsigned seq_len;
    int unsigned pick;
    logic        tail;
    logic        flipped;

    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = '0;
    cfg_data_i       = '0;
    in_vld_i         = 1'b0;
    action_i         = '0;
    number_i         = '0;
    digit_count_i    = '0;
    preamble_count_i = '0;
    gaps_on          = 1'b1;
    stall_on         = 1'b1;
    n_words = 0; n_starts = 0; n_stops = 0; n_none = 0;
    n_cfg = 0; n_checked = 0; n_errors = 0;
    n_rand = 0;

    // reset values of the predictor
    cfg_loop = 1'b1;
    cfg_tpu  = TpuW'(1);
    sq_phase = SQ_IDLE;
    sq_units = 0; sq_presc = 0; sq_digit = 0; sq_bit = 0;
    sq_ndig = 0; sq_npre = 0; sq_preleft = 0; sq_value = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; looping mode and one tick per unit after reset
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b0));
    dir_rows.push_back(word_row(ActNone,   32'hFFFFFFFF, 4'hF,  8'hFF,  1'b1, 1'b0, 1'b0));
    dir_rows.push_back(word_row(ACT_STOP,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b0));
    dir_rows.push_back(word_row(ACT_START, 32'hFFFFFFFF, 4'd15, 8'd255, 1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b1));
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ActNone,   32'h0,        4'd0,  8'd0,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ACT_STOP,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b0));
    // no digits, no preamble: straight into the 5-unit wait
    dir_rows.push_back(word_row(ACT_START, 32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b1));
    repeat (6) dir_rows.push_back(word_row(ACT_TICK, 32'h0, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_LOOPING_MODE, 21'd0));
    // single mode: digit A starts with a long pulse
    dir_rows.push_back(word_row(ACT_START, 32'h0000000A, 4'd1,  8'd3,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b0, 1'b0, 1'b0));
    // restart while busy
    dir_rows.push_back(word_row(ACT_START, 32'h00000005, 4'd2,  8'd0,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b0, 1'b0, 1'b0));
    // single mode with no digits goes idle at once
    dir_rows.push_back(word_row(ACT_START, 32'h0,        4'd0,  8'd7,   1'b1, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_TICKS_PER_UNIT, 21'd0));
    dir_rows.push_back(word_row(ACT_START, 32'h12345678, 4'd9,  8'd1,   1'b0, 1'b0, 1'b0));
    repeat (3) dir_rows.push_back(word_row(ACT_TICK, 32'h0, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_TICKS_PER_UNIT, TpuAll));
    dir_rows.push_back(word_row(ACT_START, 32'h00000009, 4'd1,  8'd2,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b1, 1'b1, 1'b1));
    dir_rows.push_back(word_row(ACT_STOP,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_TICKS_PER_UNIT, TpuTop));
    dir_rows.push_back(cfg_row(CFG_LOOPING_MODE, 21'd1));
    dir_rows.push_back(word_row(ACT_START, 32'h0000000C, 4'd1,  8'd0,   1'b1, 1'b0, 1'b1));
    dir_rows.push_back(word_row(ACT_TICK,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b1));
    dir_rows.push_back(word_row(ACT_STOP,  32'h0,        4'd0,  8'd0,   1'b1, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(CFG_TICKS_PER_UNIT, 21'd1));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        drain();
        cfg_write(row.idx, row.val);
      end else begin
        send_word(row.act, row.num, row.dc, row.pre, row.chk, row.res);
      end
    end

    // Random part: start a display, then mostly ticks with some noise
    while (n_rand < RandWords) begin
      tail     = (n_rand + TailWords >= RandWords);
      gaps_on  = !tail && ($urandom_range(0, 3) != 0);
      stall_on = !tail && ($urandom_range(0, 3) != 0);
      flipped  = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        drain();
        cfg_write(CFG_LOOPING_MODE, TpuW'($urandom_range(0, 1)));
        cfg_write(CFG_TICKS_PER_UNIT,
                  ($urandom_range(0, 9) < 7) ? TpuW'(1) : TpuW'($urandom_range(0, 4)));
      end
      send_rand_start();
      n_rand++;
      seq_len = $urandom_range(10, 160);
      repeat (seq_len) begin
        pick = $urandom_range(0, 99);
        if (pick < 86) begin
          send_word(ACT_TICK, $urandom, DigitCountW'($urandom_range(0, 15)),
                    PreambleW'($urandom_range(0, 255)), 1'b0, '0);
          n_rand++;
        end else if (pick < 91) begin
          send_word(ActNone, $urandom, DigitCountW'($urandom_range(0, 15)),
                    PreambleW'($urandom_range(0, 255)), 1'b0, '0);
        end else if (pick < 94) begin
          send_word(ACT_STOP, $urandom, DigitCountW'($urandom_range(0, 15)),
                    PreambleW'($urandom_range(0, 255)), 1'b0, '0);
          n_rand++;
        end else if (pick < 97 || flipped) begin
          send_rand_start();
          n_rand++;
        end else begin
          // mode change while the display runs
          drain();
          cfg_write(CFG_LOOPING_MODE, {20'd0, ~cfg_loop});
          flipped = 1'b1;
        end
      end
    end

    // Wind down
    drain();
    repeat (SettleDelay) @(posedge clk_i);
    $display("Covered %0d input words (%0d starts, %0d stops, %0d unknown actions)",
             n_words, n_starts, n_stops, n_none);
    $display("and %0d register writes; %0d result words checked, %0d mismatches.",
             n_cfg, n_checked, n_errors);
    if (n_errors == 0 && blink_q.size() == 0) begin
      $display("** led_hex_blink_code_sequencer_core: PASSED **");
    end else begin
      $display("** led_hex_blink_code_sequencer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/lhbs_pkg.sv
src/lhbs_cfg_regs.sv
src/lhbs_in_stage.sv
src/lhbs_seq.sv
src/led_hex_blink_code_sequencer_core.sv
dv/tb_top.sv
